// File: sv/spq_pkg.sv
// Package for the stable priority queue: widths, status and mode codes, shared types.
package spq_pkg;

   localparam int ValueW       = 32;
   localparam int PrioW        = 8;
   localparam int StatusW      = 2;
   localparam int OccW         = 5;
   localparam int CsrW         = 5;
   localparam int DepthDefault = 16;

   localparam logic [CsrW-1:0] CapacityReset = 5'd16;

   localparam logic ModeInsert = 1'b0;
   localparam logic ModeRemove = 1'b1;

   localparam logic [StatusW-1:0] StInserted = 2'd0;
   localparam logic [StatusW-1:0] StFull     = 2'd1;
   localparam logic [StatusW-1:0] StRemoved  = 2'd2;
   localparam logic [StatusW-1:0] StEmpty    = 2'd3;

   // One stored entry of the queue.
   typedef struct packed {
      logic                     valid;
      logic signed [ValueW-1:0] value;
      logic [PrioW-1:0]         prio;
   } spq_entry_type;

   // Operation broadcast to every cell in a cycle.
   typedef struct packed {
      logic                     insert;
      logic                     remove;
      logic signed [ValueW-1:0] value;
      logic [PrioW-1:0]         prio;
   } spq_ctrl_type;

endpackage

// File: sv/spq_cell.sv
// One cell of the sorted queue chain: holds an entry and trades it with its neighbours.
module spq_cell (
   input  logic                  clock,
   input  logic                  reset,
   input  spq_pkg::spq_ctrl_type  ctrl,
   input  spq_pkg::spq_entry_type prev_entry,
   input  logic                  prev_stays,
   input  spq_pkg::spq_entry_type next_entry,
   output spq_pkg::spq_entry_type entry,
   output logic                  stays
);
   import spq_pkg::*;

   spq_entry_type entry_ff;
   spq_entry_type entry_in;

   // The new entry belongs behind every entry of equal or higher priority,
   // which keeps equal priorities in arrival order.
   assign stays = entry_ff.valid && (entry_ff.prio >= ctrl.prio);
   assign entry = entry_ff;

   always_comb begin
      entry_in = entry_ff;
      priority if (ctrl.remove) begin
         entry_in = next_entry;
      end else if (ctrl.insert && !stays) begin
         if (prev_stays) begin
            entry_in.valid = 1'b1;
            entry_in.value = ctrl.value;
            entry_in.prio  = ctrl.prio;
         end else begin
            entry_in = prev_entry;
         end
      end
   end

   always_ff @(posedge clock) begin
      entry_ff.value <= entry_in.value;
      entry_ff.prio  <= entry_in.prio;
      if (reset) begin
         entry_ff.valid <= 1'b0;
      end else begin
         entry_ff.valid <= entry_in.valid;
      end
   end

endmodule

// File: sv/stable_priority_queue.sv
// Top level of the stable priority queue: a sorted chain of cells with a registered result.
//
//   channel   direction  handshake               payload
//   req_      in         req_valid / req_ready   mode, item_value, priority_req
//   rsp_      out        rsp_valid / rsp_ready   status, out_value, out_priority, occupancy
//   csr_      in         csr_wr_en               capacity (csr_wr_data)
//
// Each request is accepted, the cells update at the same edge and the
// result appears in the output register in the next cycle. One request a cycle is sustained
// while rsp_ready stays high; the single compare in each cell sets that figure.
// A synchronous reset empties the chain (valid bits only) and sets capacity to sixteen;
// there is no clearing pass.
// While a result waits for rsp_ready, req_ready is low and the cells hold.
module stable_priority_queue #(
   parameter int DEPTH = spq_pkg::DepthDefault
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_valid,
   output logic                               req_ready,
   input  logic                               req_mode,
   input  logic signed [spq_pkg::ValueW-1:0]  req_item_value,
   input  logic [spq_pkg::PrioW-1:0]          req_priority_req,
   output logic                               rsp_valid,
   input  logic                               rsp_ready,
   output logic [spq_pkg::StatusW-1:0]        rsp_status,
   output logic signed [spq_pkg::ValueW-1:0]  rsp_out_value,
   output logic [spq_pkg::PrioW-1:0]          rsp_out_priority,
   output logic [spq_pkg::OccW-1:0]           rsp_occupancy,
   input  logic                               csr_wr_en,
   input  logic [spq_pkg::CsrW-1:0]           csr_wr_data
);
   import spq_pkg::*;

   // The live count must reach DEPTH itself; comparisons run at the wider of the
   // count width and the capacity register width.
   localparam int CntW = $clog2(DEPTH + 1);
   localparam int CmpW = (CntW > CsrW) ? CntW : CsrW;

   logic [CsrW-1:0]          capacity_ff;
   logic [CntW-1:0]          live_ff;
   logic [CntW-1:0]          live_in;
   logic                     rsp_valid_ff;
   logic                     rsp_valid_in;
   logic [StatusW-1:0]       status_ff;
   logic [StatusW-1:0]       status_in;
   logic signed [ValueW-1:0] value_ff;
   logic signed [ValueW-1:0] value_in;
   logic [PrioW-1:0]         prio_ff;
   logic [PrioW-1:0]         prio_in;
   logic [OccW-1:0]          occ_ff;
   logic [OccW-1:0]          occ_in;

   logic                     accept;
   logic                     full;
   logic                     empty;
   logic [CmpW-1:0]          live_wide;
   spq_ctrl_type             ctrl;

   spq_entry_type            cell_entry [DEPTH];
   logic                     cell_stays [DEPTH];

   // A finished result blocks the next request only until it is taken.
   assign req_ready = !rsp_valid_ff || rsp_ready;
   assign accept    = req_valid && req_ready;

   // The limit is the smaller of the capacity register and the chain length; a
   // capacity lowered below the live count simply rejects inserts for a while.
   assign full  = (CmpW'(live_ff) >= CmpW'(capacity_ff)) || (live_ff >= CntW'(DEPTH));
   assign empty = (live_ff == '0);

   always_comb begin
      ctrl.insert = accept && (req_mode == ModeInsert) && !full;
      ctrl.remove = accept && (req_mode == ModeRemove) && !empty;
      ctrl.value  = req_item_value;
      ctrl.prio   = req_priority_req;
   end

   // The chain is kept sorted by priority, highest first, with equal priorities in
   // arrival order. The head cell therefore always holds the entry to remove next.
   for (genvar i = 0; i < DEPTH; i++) begin : g_cell
      spq_entry_type prev_entry;
      spq_entry_type next_entry;
      logic          prev_stays;

      if (i == 0) begin : g_head
         // Nothing stands ahead of the head, so an insert that passes it lands here.
         assign prev_entry = '0;
         assign prev_stays = 1'b1;
      end else begin : g_body
         assign prev_entry = cell_entry[i-1];
         assign prev_stays = cell_stays[i-1];
      end

      if (i == DEPTH - 1) begin : g_tail
         assign next_entry = '0;
      end else begin : g_inner
         assign next_entry = cell_entry[i+1];
      end

      spq_cell u_cell (
         .clock      (clock),
         .reset      (reset),
         .ctrl       (ctrl),
         .prev_entry (prev_entry),
         .prev_stays (prev_stays),
         .next_entry (next_entry),
         .entry      (cell_entry[i]),
         .stays      (cell_stays[i])
      );
   end

   always_comb begin
      live_in      = live_ff;
      rsp_valid_in = rsp_valid_ff;
      status_in    = status_ff;
      value_in     = value_ff;
      prio_in      = prio_ff;
      if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
      if (accept) begin
         rsp_valid_in = 1'b1;
         value_in     = '0;
         prio_in      = '0;
         priority if (ctrl.insert) begin
            live_in   = live_ff + CntW'(1);
            status_in = StInserted;
         end else if (ctrl.remove) begin
            live_in   = live_ff - CntW'(1);
            status_in = StRemoved;
            value_in  = cell_entry[0].value;
            prio_in   = cell_entry[0].prio;
         end else if (req_mode == ModeInsert) begin
            status_in = StFull;
         end else begin
            status_in = StEmpty;
         end
      end
   end

   // Occupancy reports the count after the request, cut to the field width.
   assign live_wide = CmpW'(live_in);
   assign occ_in    = accept ? live_wide[OccW-1:0] : occ_ff;

   always_ff @(posedge clock) begin
      status_ff <= status_in;
      value_ff  <= value_in;
      prio_ff   <= prio_in;
      occ_ff    <= occ_in;
      if (reset) begin
         capacity_ff  <= CapacityReset;
         live_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         live_ff      <= live_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_wr_en) begin
            capacity_ff <= csr_wr_data;
         end
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_status       = status_ff;
   assign rsp_out_value    = value_ff;
   assign rsp_out_priority = prio_ff;
   assign rsp_occupancy    = occ_ff;

endmodule

// File: sv/spq_checker.sv
// Port-level checks for the stable priority queue, bound to the top level.
module spq_checker (
   input logic                               clock,
   input logic                               reset,
   input logic                               req_valid,
   input logic                               req_ready,
   input logic                               rsp_valid,
   input logic                               rsp_ready,
   input logic [spq_pkg::StatusW-1:0]        rsp_status,
   input logic signed [spq_pkg::ValueW-1:0]  rsp_out_value,
   input logic [spq_pkg::PrioW-1:0]          rsp_out_priority,
   input logic [spq_pkg::OccW-1:0]           rsp_occupancy
);
   import spq_pkg::*;

   // A stalled result holds its payload.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_status)
         && $stable(rsp_out_value) && $stable(rsp_out_priority) && $stable(rsp_occupancy))
      else $error("result changed while stalled");

   // Every accepted request yields its result in the next cycle.
   a_one_cycle: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> rsp_valid)
      else $error("accepted request gave no result");

   // Only a removal carries a value and a priority.
   a_zero_payload: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_status != StRemoved) |-> (rsp_out_value == '0)
         && (rsp_out_priority == '0))
      else $error("payload set on a result that is not a removal");

   // An empty report leaves nothing behind.
   a_empty_occ: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_status == StEmpty) |-> (rsp_occupancy == '0))
      else $error("empty result with nonzero occupancy");

endmodule

bind stable_priority_queue spq_checker u_spq_checker (.*);
